### src/rgbcfp_pkg.sv
// ----------------------------------------------------------------------------
// rgbcfp_pkg
// shared codes and types for the rgb command frame parser
// ----------------------------------------------------------------------------
package rgbcfp_pkg;

    // frame phases
    localparam logic [2:0] PH_HEAD  = 3'd0;
    localparam logic [2:0] PH_RED   = 3'd1;
    localparam logic [2:0] PH_GREEN = 3'd2;
    localparam logic [2:0] PH_BLUE  = 3'd3;
    localparam logic [2:0] PH_TAIL  = 3'd4;
    localparam logic [2:0] PH_TOSEL = 3'd5;

    // frame markers
    localparam logic [7:0] HDR_COLOR   = 8'hA0;
    localparam logic [7:0] HDR_TIMEOUT = 8'hA1;
    localparam logic [7:0] HDR_VER_LO  = 8'h76;
    localparam logic [7:0] HDR_VER_UP  = 8'h56;
    localparam logic [7:0] TAIL_MARK   = 8'hC0;
    localparam logic [7:0] TIMEOUT_LIMIT = 8'd21;

    // event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_COLOR   = 3'd1;
    localparam logic [2:0] EV_TIMEOUT = 3'd2;
    localparam logic [2:0] EV_VERSION = 3'd3;
    localparam logic [2:0] EV_ERROR   = 3'd4;

    // one result transaction
    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [4:0] timeout_value;
        logic       frame_timer_run;
    } res_t;

endpackage

### src/rgbcfp_parser.sv
// ----------------------------------------------------------------------------
// rgbcfp_parser
// frame state machine: holds the parse state and works out one step's result
// ----------------------------------------------------------------------------
module rgbcfp_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic               cmd,
    input  logic [7:0]         rx_byte,
    output rgbcfp_pkg::res_t   res
);
    import rgbcfp_pkg::*;

    logic [2:0] phase_reg,   phase_next;
    logic [7:0] header_reg,  header_next;
    logic [4:0] timeout_reg, timeout_next;
    logic [7:0] red_reg,     red_next;
    logic [7:0] green_reg,   green_next;
    logic [7:0] blue_reg,    blue_next;
    logic [2:0] ev;

    always_comb begin
        phase_next   = phase_reg;
        header_next  = header_reg;
        timeout_next = timeout_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        ev           = EV_NONE;

        if (cmd) begin
            // frame timeout only matters mid-frame
            if (phase_reg inside {PH_RED, PH_GREEN, PH_BLUE, PH_TAIL, PH_TOSEL}) begin
                ev          = EV_ERROR;
                header_next = '0;
                phase_next  = PH_HEAD;
            end
        end else begin
            case (phase_reg)
                PH_TOSEL: begin
                    if (rx_byte == 8'd0 || rx_byte >= TIMEOUT_LIMIT) begin
                        ev          = EV_ERROR;
                        header_next = '0;
                        phase_next  = PH_HEAD;
                    end else begin
                        timeout_next = rx_byte[4:0];
                        phase_next   = PH_TAIL;
                    end
                end
                PH_RED: begin
                    red_next   = rx_byte;
                    phase_next = PH_GREEN;
                end
                PH_GREEN: begin
                    green_next = rx_byte;
                    phase_next = PH_BLUE;
                end
                PH_BLUE: begin
                    blue_next  = rx_byte;
                    phase_next = PH_TAIL;
                end
                PH_TAIL: begin
                    if (rx_byte == TAIL_MARK && header_reg == HDR_TIMEOUT) begin
                        ev         = EV_TIMEOUT;
                        phase_next = PH_HEAD;
                    end else if (rx_byte == TAIL_MARK && header_reg == HDR_COLOR) begin
                        ev         = EV_COLOR;
                        phase_next = PH_HEAD;
                    end else begin
                        ev          = EV_ERROR;
                        header_next = '0;
                        phase_next  = PH_HEAD;
                    end
                end
                default: begin
                    // header wait, unused codes behave the same
                    header_next = rx_byte;
                    phase_next  = PH_HEAD;
                    if (rx_byte == HDR_TIMEOUT) begin
                        phase_next = PH_TOSEL;
                    end else if (rx_byte == HDR_COLOR) begin
                        phase_next = PH_RED;
                    end else if (rx_byte == HDR_VER_LO || rx_byte == HDR_VER_UP) begin
                        ev = EV_VERSION;
                    end else begin
                        ev          = EV_ERROR;
                        header_next = '0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        res.event_res       = ev;
        res.red_out         = red_next;
        res.green_out       = green_next;
        res.blue_out        = blue_next;
        res.timeout_value   = timeout_next;
        res.frame_timer_run = (phase_next != PH_HEAD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEAD;
            header_reg  <= '0;
            timeout_reg <= '0;
            red_reg     <= '0;
            green_reg   <= '0;
            blue_reg    <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            header_reg  <= header_next;
            timeout_reg <= timeout_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
        end
    end

endmodule

### src/rgb_command_frame_parser_top.sv
// a transaction passes the input register, then the result register; its result is valid once it
// is in the result register, and a full result register that is not read holds it back
// throughput: one transaction per cycle as long as m_ready keeps the result register draining
// the input side keeps taking transactions while a result waits, up to one held in each register
// reset (aresetn low, synchronous): header wait, stored header, timeout and color levels cleared
// ----------------------------------------------------------------------------
// rgb_command_frame_parser_top
// parses received serial bytes into color, timeout and version command frames
// ----------------------------------------------------------------------------
module rgb_command_frame_parser_top (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [7:0] s_rx_byte,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [7:0] m_red_out,
    output logic [7:0] m_green_out,
    output logic [7:0] m_blue_out,
    output logic [4:0] m_timeout_value,
    output logic       m_frame_timer_run
);
    import rgbcfp_pkg::*;

    // input register stage
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;

    // result register stage
    logic       out_valid_reg;
    res_t       out_reg;

    res_t       step_res;
    logic       advance;

    // a held transaction moves on when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // input register refills when empty or when its content moves on this cycle
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg  <= s_cmd;
            in_byte_reg <= s_rx_byte;
        end
    end

    // parse state advances exactly once per transaction
    rgbcfp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .cmd     (in_cmd_reg),
        .rx_byte (in_byte_reg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_event_res       = out_reg.event_res;
    assign m_red_out         = out_reg.red_out;
    assign m_green_out       = out_reg.green_out;
    assign m_blue_out        = out_reg.blue_out;
    assign m_timeout_value   = out_reg.timeout_value;
    assign m_frame_timer_run = out_reg.frame_timer_run;

endmodule

### sim/rgb_command_frame_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_command_frame_parser_top_tb
// self-checking bench: a directed table covering the frame corner cases is
// followed by random color, timeout and version frames, some broken or
// aborted. A behavioral parser copy predicts each result not set by hand, and the
// block's results are compared field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module rgb_command_frame_parser_top_tb;

    import rgbcfp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 8;

    // one input transaction, with an optional hand-written expectation
    typedef struct {
        logic       cmd;
        logic [7:0] rx;
        bit         known;
        res_t       want;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_cmd = 1'b0;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_event_res;
    logic [7:0] m_red_out;
    logic [7:0] m_green_out;
    logic [7:0] m_blue_out;
    logic [4:0] m_timeout_value;
    logic       m_frame_timer_run;

    rgb_command_frame_parser_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_res       (m_event_res),
        .m_red_out         (m_red_out),
        .m_green_out       (m_green_out),
        .m_blue_out        (m_blue_out),
        .m_timeout_value   (m_timeout_value),
        .m_frame_timer_run (m_frame_timer_run)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // parser prediction: private copy of the frame state
    // ------------------------------------------------------------------
    logic [2:0] pr_phase   = PH_HEAD;
    logic [7:0] pr_header  = 8'h00;
    logic [4:0] pr_timeout = 5'd0;
    logic [7:0] pr_red     = 8'h00;
    logic [7:0] pr_green   = 8'h00;
    logic [7:0] pr_blue    = 8'h00;

    // abandon the frame in progress, report an error
    function automatic logic [2:0] drop_frame();
        pr_header = 8'h00;
        pr_phase  = PH_HEAD;
        return EV_ERROR;
    endfunction

    // advance the frame state by one received byte or timer event
    function automatic res_t parse_step(input logic cmd, input logic [7:0] rx);
        res_t       r;
        logic [2:0] ev;
        ev = EV_NONE;
        if (pr_phase > PH_TOSEL) begin
            pr_phase = PH_HEAD;
        end
        if (cmd) begin
            // timer event only matters inside a frame
            if (pr_phase != PH_HEAD) begin
                ev = drop_frame();
            end
        end else begin
            case (pr_phase)
                PH_HEAD: begin
                    pr_header = rx;
                    if (rx == HDR_TIMEOUT) begin
                        pr_phase = PH_TOSEL;
                    end else if (rx == HDR_COLOR) begin
                        pr_phase = PH_RED;
                    end else if (rx == HDR_VER_LO || rx == HDR_VER_UP) begin
                        ev = EV_VERSION;
                    end else begin
                        ev = drop_frame();
                    end
                end
                PH_TOSEL: begin
                    if (rx == 8'd0 || rx >= TIMEOUT_LIMIT) begin
                        ev = drop_frame();
                    end else begin
                        pr_timeout = rx[4:0];
                        pr_phase   = PH_TAIL;
                    end
                end
                PH_RED: begin
                    pr_red   = rx;
                    pr_phase = PH_GREEN;
                end
                PH_GREEN: begin
                    pr_green = rx;
                    pr_phase = PH_BLUE;
                end
                PH_BLUE: begin
                    pr_blue  = rx;
                    pr_phase = PH_TAIL;
                end
                default: begin
                    if (rx == TAIL_MARK && pr_header == HDR_TIMEOUT) begin
                        ev       = EV_TIMEOUT;
                        pr_phase = PH_HEAD;
                    end else if (rx == TAIL_MARK && pr_header == HDR_COLOR) begin
                        ev       = EV_COLOR;
                        pr_phase = PH_HEAD;
                    end else begin
                        ev = drop_frame();
                    end
                end
            endcase
        end
        r.event_res       = ev;
        r.red_out         = pr_red;
        r.green_out       = pr_green;
        r.blue_out        = pr_blue;
        r.timeout_value   = pr_timeout;
        r.frame_timer_run = (pr_phase != PH_HEAD);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus table
    // ------------------------------------------------------------------
    stim_row_t stim_q[$];
    res_t      pending_res_q[$];
    int        mismatch_cnt = 0;
    int        cycle_cnt = 0;
    int        stall_left = 0;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    task automatic add_row(input logic cmd, input logic [7:0] rx);
        stim_row_t row;
        row.cmd   = cmd;
        row.rx    = rx;
        row.known = 1'b0;
        row.want  = '0;
        stim_q.push_back(row);
    endtask

    task automatic add_known(input logic cmd, input logic [7:0] rx, input logic [2:0] ev,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [4:0] t, input logic run);
        stim_row_t row;
        row.cmd   = cmd;
        row.rx    = rx;
        row.known = 1'b1;
        row.want  = '{ev, r, g, b, t, run};
        stim_q.push_back(row);
    endtask

    // one random frame, well formed most of the time; returns how many
    // transactions it holds that the parser actually acts on
    task automatic add_random_frame(output int counted);
        int         kind;
        int         n;
        logic [7:0] hdr;
        logic [7:0] val;
        logic [7:0] tail;
        kind = $urandom_range(0, 99);
        tail = ($urandom_range(0, 9) != 0) ? TAIL_MARK : 8'($urandom_range(0, 255));
        if (kind < 40) begin
            add_row(1'b0, HDR_COLOR);
            repeat (3) add_row(1'b0, 8'($urandom_range(0, 255)));
            add_row(1'b0, tail);
            counted = 5;
        end else if (kind < 65) begin
            n = $urandom_range(0, 9);
            if (n < 8) val = 8'($urandom_range(1, 20));
            else if (n == 8) val = 8'd0;
            else val = 8'($urandom_range(21, 255));
            add_row(1'b0, HDR_TIMEOUT);
            add_row(1'b0, val);
            // an out-of-range value already closed the frame, tail becomes a header
            add_row(1'b0, tail);
            counted = 3;
        end else if (kind < 75) begin
            add_row(1'b0, $urandom_range(0, 1) ? HDR_VER_LO : HDR_VER_UP);
            counted = 1;
        end else if (kind < 85) begin
            // frame cut short by the external timer at any phase
            hdr = $urandom_range(0, 1) ? HDR_COLOR : HDR_TIMEOUT;
            add_row(1'b0, hdr);
            n = $urandom_range(0, (hdr == HDR_COLOR) ? 3 : 1);
            for (int i = 0; i < n; i++) begin
                add_row(1'b0, (hdr == HDR_TIMEOUT) ? 8'($urandom_range(1, 20))
                                                 : 8'($urandom_range(0, 255)));
            end
            add_row(1'b1, 8'($urandom_range(0, 255)));
            counted = n + 2;
        end else if (kind < 95) begin
            add_row(1'b0, 8'($urandom_range(0, 255)));
            counted = 1;
        end else begin
            // timer event outside a frame, ignored by the parser
            add_row(1'b1, 8'($urandom_range(0, 255)));
            counted = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic cmp_field(input string fname, input int unsigned want,
                             input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic check_result();
        res_t want;
        if (pending_res_q.size() == 0) begin
            $display("%0t: unexpected result transaction, event %0d", $time, m_event_res);
            mismatch_cnt++;
        end else begin
            want = pending_res_q.pop_front();
            cmp_field("event_res", 32'(want.event_res), 32'(m_event_res));
            cmp_field("red_out", 32'(want.red_out), 32'(m_red_out));
            cmp_field("green_out", 32'(want.green_out), 32'(m_green_out));
            cmp_field("blue_out", 32'(want.blue_out), 32'(m_blue_out));
            cmp_field("timeout_value", 32'(want.timeout_value), 32'(m_timeout_value));
            cmp_field("frame_timer_run", 32'(want.frame_timer_run),
                      32'(m_frame_timer_run));
        end
    endtask

    // result side: check every accepted transaction, then pick the next
    // ready value; stalls are picked only while bit 10 of the cycle counter is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (cycle_cnt[10]) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("rgb_command_frame_parser_top_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int   counted;
        int   total;
        int   gap;
        res_t pred;

        // directed table, state starts cleared
        add_known(1'b1, TAIL_MARK, EV_NONE, 8'h00, 8'h00, 8'h00, 5'd0, 1'b0); // timer, idle
        add_known(1'b0, 8'hFF, EV_ERROR, 8'h00, 8'h00, 8'h00, 5'd0, 1'b0);    // unknown header
        add_known(1'b0, 8'h00, EV_ERROR, 8'h00, 8'h00, 8'h00, 5'd0, 1'b0);
        add_known(1'b0, HDR_VER_LO, EV_VERSION, 8'h00, 8'h00, 8'h00, 5'd0, 1'b0);
        add_known(1'b0, HDR_VER_UP, EV_VERSION, 8'h00, 8'h00, 8'h00, 5'd0, 1'b0);
        // color frame with extreme levels
        add_row(1'b0, HDR_COLOR);
        add_row(1'b0, 8'hFF);
        add_row(1'b0, 8'h00);
        add_row(1'b0, 8'hFF);
        add_known(1'b0, TAIL_MARK, EV_COLOR, 8'hFF, 8'h00, 8'hFF, 5'd0, 1'b0);
        // timeout values just outside the range
        add_row(1'b0, HDR_TIMEOUT);
        add_known(1'b0, 8'd0, EV_ERROR, 8'hFF, 8'h00, 8'hFF, 5'd0, 1'b0);
        add_row(1'b0, HDR_TIMEOUT);
        add_known(1'b0, TIMEOUT_LIMIT, EV_ERROR, 8'hFF, 8'h00, 8'hFF, 5'd0, 1'b0);
        // lowest accepted timeout
        add_row(1'b0, HDR_TIMEOUT);
        add_row(1'b0, 8'd1);
        add_known(1'b0, TAIL_MARK, EV_TIMEOUT, 8'hFF, 8'h00, 8'hFF, 5'd1, 1'b0);
        // highest timeout, bad tail: value is kept anyway
        add_row(1'b0, HDR_TIMEOUT);
        add_row(1'b0, 8'd20);
        add_known(1'b0, 8'h55, EV_ERROR, 8'hFF, 8'h00, 8'hFF, 5'd20, 1'b0);
        // color frame cut by the timer keeps the red already taken
        add_row(1'b0, HDR_COLOR);
        add_row(1'b0, 8'h12);
        add_known(1'b1, 8'h00, EV_ERROR, 8'h12, 8'h00, 8'hFF, 5'd20, 1'b0);
        // timer while waiting for the timeout value
        add_row(1'b0, HDR_TIMEOUT);
        add_known(1'b1, 8'hFF, EV_ERROR, 8'h12, 8'h00, 8'hFF, 5'd20, 1'b0);
        // color frame with a bad tail
        add_row(1'b0, HDR_COLOR);
        add_row(1'b0, 8'h00);
        add_row(1'b0, 8'hFF);
        add_row(1'b0, 8'h00);
        add_known(1'b0, 8'h3F, EV_ERROR, 8'h00, 8'hFF, 8'h00, 5'd20, 1'b0);

        // random frames
        total = 0;
        while (total < RANDOM_ITEMS) begin
            add_random_frame(counted);
            total += counted;
        end

        // hold reset, then release it
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // walk the table; every other 64-row stretch goes without gaps
        for (int i = 0; i < stim_q.size(); i++) begin
            gap = (i % 128 < 64) ? pick_gap() : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid   <= 1'b1;
            s_cmd     <= stim_q[i].cmd;
            s_rx_byte <= stim_q[i].rx;
            do @(posedge aclk); while (!s_ready);
            // transaction taken at this edge
            pred = parse_step(stim_q[i].cmd, stim_q[i].rx);
            pending_res_q.push_back(stim_q[i].known ? stim_q[i].want : pred);
        end
        s_valid <= 1'b0;

        // drain, then allow for anything still in the pipeline
        while (pending_res_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0 && pending_res_q.size() == 0) begin
            $display("rgb_command_frame_parser_top_tb: done, clean");
        end else begin
            $display("rgb_command_frame_parser_top_tb: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
src/rgbcfp_pkg.sv
src/rgbcfp_parser.sv
src/rgb_command_frame_parser_top.sv
sim/rgb_command_frame_parser_top_tb.sv
